// ===== rtl/core/iald_pkg.sv =====
// Package for the idle-aware load dispatcher: sizes, codes and shared types.
// Used by iald_ctrl, iald_dp and the top level under rtl/core.
package iald_pkg;
    localparam int SERVERS     = 16;
    localparam int HISTORY_MAX = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int SRV_W       = 4;
    localparam int HIST_W      = 4;
    localparam int TOTAL_W     = 20;
    localparam int SUM_W       = COUNT_WIDTH + SRV_W;

    typedef enum logic [1:0] {
        ALG_JSQ  = 2'd0,
        ALG_JIQ  = 2'd1,
        ALG_PI   = 2'd2,
        ALG_PIK  = 2'd3
    } alg_t;

    localparam logic [0:0] CFG_ALGORITHM = 1'b0;
    localparam logic [0:0] CFG_DEPTH     = 1'b1;
    localparam logic OP_DISPATCH = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOD,
        ST_PICK,
        ST_UPDATE,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic mod_start;
        logic pick_start;
        logic pick_step;
        logic update;
        logic sum_start;
        logic sum_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_dispatch;
        logic scan_last;
        logic mod_done;
        logic need_pick;
        logic pick_last;
        logic sum_last;
    } sts_t;
endpackage

// ===== rtl/core/iald_ctrl.sv =====
// Controller of the dispatcher: sequences scan, modulo, pick, update, sum, output.
// Depends on iald_pkg.
module iald_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic             out_busy,
    input  iald_pkg::sts_t   sts,
    output iald_pkg::cmd_t   cmd,
    output logic             in_ready
);
    import iald_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_SCAN;
            ST_SCAN:   if (sts.scan_last) state_next = ST_MOD;
            ST_MOD:    if (sts.mod_done) state_next = sts.need_pick ? ST_PICK : ST_UPDATE;
            ST_PICK:   if (sts.pick_last) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_SUM;
            ST_SUM:    if (sts.sum_last) state_next = ST_OUT;
            ST_OUT:    if (!out_busy) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready       = 1'b1;
                cmd.load       = in_fire;
                cmd.scan_start = in_fire;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                cmd.mod_start = sts.scan_last;
            end
            ST_MOD: begin
                cmd.pick_start = sts.mod_done;
            end
            ST_PICK: cmd.pick_step = 1'b1;
            ST_UPDATE: begin
                cmd.update    = 1'b1;
                cmd.sum_start = 1'b1;
            end
            ST_SUM: cmd.sum_step = 1'b1;
            ST_OUT: cmd.out_load = !out_busy;
            default: cmd = '0;
        endcase
    end
endmodule

// ===== rtl/core/iald_dp.sv =====
// Datapath of the dispatcher: counts, history FIFO, serial scan, modulo, sum.
// Depends on iald_pkg; driven by iald_ctrl.
module iald_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  iald_pkg::cmd_t                 cmd,
    output iald_pkg::sts_t                 sts,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [3:0]                     cfg_data,
    input  logic                           s_operation,
    input  logic [7:0]                     s_task_count,
    input  logic [iald_pkg::SRV_W-1:0]     s_server_index,
    input  logic [15:0]                    s_done_count,
    input  logic [15:0]                    s_random_pick,
    output logic [iald_pkg::SRV_W-1:0]     res_server,
    output logic [15:0]                    res_length,
    output logic                           res_idled,
    output logic [iald_pkg::TOTAL_W-1:0]   res_total
);
    import iald_pkg::*;

    logic [COUNT_WIDTH-1:0] qlen_reg [SERVERS];
    logic [SRV_W-1:0]  hist_reg [HISTORY_MAX];
    logic [HIST_W-1:0] fill_reg;
    logic [SRV_W-1:0]  last_idle_reg;
    alg_t              alg_reg;
    logic [3:0]        depth_reg;

    logic              op_reg;
    logic [7:0]        tasks_reg;
    logic [SRV_W-1:0]  idx_reg;
    logic [15:0]       done_reg;
    logic [15:0]       rnd_reg;

    logic [SRV_W-1:0]       ptr_reg;
    logic [COUNT_WIDTH-1:0] min_reg;
    logic [SRV_W:0]         nmin_reg;
    logic [SRV_W:0]         nidle_reg;

    // candidate set: servers equal to target (pick_reg), history (use_hist_reg) or direct
    logic [COUNT_WIDTH-1:0] target_reg;
    logic                   use_hist_reg;
    logic [15:0]            rem_reg;
    logic [SRV_W:0]         div_reg;
    logic [4:0]             mstep_reg;
    logic [SRV_W:0]         seen_reg;
    logic [SRV_W-1:0]       srv_reg;
    logic                   pick_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SRV_W-1:0]       len_ix;

    // serial restoring modulo: one quotient bit per cycle, MSB first
    logic rnd_bit;
    assign rnd_bit = rnd_reg[4'd15 - mstep_reg[3:0]];

    logic [3:0] k_eff;
    assign k_eff = (depth_reg == 4'd0) ? 4'd1 :
                   (depth_reg > 4'(HISTORY_MAX)) ? 4'(HISTORY_MAX) : depth_reg;

    logic [HIST_W-1:0] drop;
    assign drop = fill_reg - k_eff + 4'd1;

    logic [COUNT_WIDTH-1:0] cur;
    assign cur = qlen_reg[ptr_reg];

    // dispatch arithmetic
    logic [COUNT_WIDTH:0] add_v;
    logic [COUNT_WIDTH-1:0] new_len;
    logic [COUNT_WIDTH-1:0] old_c;
    logic                   idx_ok;
    assign idx_ok = 1'b1;
    assign old_c  = qlen_reg[idx_reg];
    assign add_v  = {1'b0, qlen_reg[srv_reg]} + (COUNT_WIDTH+1)'(tasks_reg);

    assign sts.is_dispatch = (op_reg == OP_DISPATCH);
    assign sts.scan_last   = (ptr_reg == SRV_W'(SERVERS-1));
    assign sts.mod_done    = (mstep_reg == 5'd17);
    assign sts.need_pick   = pick_reg;
    assign sts.pick_last   = (ptr_reg == SRV_W'(SERVERS-1));
    assign sts.sum_last    = (ptr_reg == SRV_W'(SERVERS-1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alg_reg   <= ALG_JSQ;
            depth_reg <= 4'd1;
        end else if (cfg_we) begin
            if (cfg_index == CFG_ALGORITHM) alg_reg <= alg_t'(cfg_data[1:0]);
            else depth_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SERVERS; i++) qlen_reg[i] <= '0;
            fill_reg      <= '0;
            last_idle_reg <= '0;
        end else if (cmd.update) begin
            if (op_reg == OP_DISPATCH) begin
                qlen_reg[srv_reg] <= add_v[COUNT_WIDTH] ? '1 : add_v[COUNT_WIDTH-1:0];
                if (alg_reg == ALG_PI && nidle_reg != '0) last_idle_reg <= srv_reg;
            end else if (idx_ok) begin
                qlen_reg[idx_reg] <= (COUNT_WIDTH'(done_reg) >= old_c) ? '0
                                     : old_c - COUNT_WIDTH'(done_reg);
                if (old_c != '0 && COUNT_WIDTH'(done_reg) >= old_c && alg_reg == ALG_PIK)
                begin
                    if (fill_reg >= k_eff) begin
                        for (int i = 0; i < HISTORY_MAX; i++) begin
                            if (i + int'(drop) < HISTORY_MAX)
                                hist_reg[i] <= hist_reg[3'(i + int'(drop))];
                        end
                        hist_reg[3'(k_eff - 4'd1)] <= idx_reg;
                        fill_reg <= k_eff;
                    end else begin
                        hist_reg[fill_reg[2:0]] <= idx_reg;
                        fill_reg <= fill_reg + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_operation;
            tasks_reg <= s_task_count;
            idx_reg   <= s_server_index;
            done_reg  <= s_done_count;
            rnd_reg   <= s_random_pick;
        end
        if (cmd.scan_start || cmd.pick_start || cmd.sum_start) ptr_reg <= '0;
        else if (cmd.scan_step || cmd.pick_step || cmd.sum_step) ptr_reg <= ptr_reg + 1'b1;

        if (cmd.scan_start) begin
            min_reg   <= '1;
            nmin_reg  <= '0;
            nidle_reg <= '0;
        end else if (cmd.scan_step) begin
            if (cur < min_reg) begin
                min_reg  <= cur;
                nmin_reg <= (SRV_W+1)'(1);
            end else if (cur == min_reg) begin
                nmin_reg <= nmin_reg + 1'b1;
            end
            if (cur == '0) nidle_reg <= nidle_reg + 1'b1;
        end

        if (cmd.mod_start) begin
            rem_reg   <= '0;
            mstep_reg <= '0;
            use_hist_reg <= 1'b0;
            pick_reg  <= 1'b1;
            srv_reg   <= '0;
            // settle candidate set from the scan result (cur is last entry)
            if (alg_reg == ALG_JSQ) begin
                target_reg <= (cur < min_reg) ? cur : min_reg;
                div_reg <= (cur < min_reg) ? (SRV_W+1)'(1)
                         : (cur == min_reg) ? nmin_reg + 1'b1 : nmin_reg;
            end else if (nidle_reg != '0 || cur == '0) begin
                target_reg <= '0;
                div_reg <= nidle_reg + ((cur == '0) ? 1'b1 : 1'b0);
            end else if (alg_reg == ALG_PI) begin
                pick_reg <= 1'b0;
                div_reg  <= (SRV_W+1)'(SERVERS);
            end else if (alg_reg == ALG_PIK && fill_reg != '0) begin
                use_hist_reg <= 1'b1;
                pick_reg <= 1'b0;
                div_reg  <= (SRV_W+1)'(fill_reg);
            end else begin
                pick_reg <= 1'b0;
                div_reg  <= (SRV_W+1)'(SERVERS);
            end
        end else if (!sts.mod_done && mstep_reg != 5'd17) begin
            mstep_reg <= mstep_reg + 1'b1;
            if (mstep_reg < 5'd16) begin
                if ({rem_reg, rnd_bit} >= 17'(div_reg))
                    rem_reg <= 16'({rem_reg, rnd_bit} - 17'(div_reg));
                else
                    rem_reg <= {rem_reg[14:0], rnd_bit};
            end else begin
                // finalize direct picks
                if (!pick_reg) begin
                    if (use_hist_reg) srv_reg <= hist_reg[rem_reg[2:0]];
                    else if (alg_reg == ALG_PI && nidle_reg == '0) srv_reg <= last_idle_reg;
                    else srv_reg <= rem_reg[SRV_W-1:0];
                end
            end
        end

        if (cmd.pick_start) seen_reg <= '0;
        else if (cmd.pick_step && cur == target_reg) begin
            if (seen_reg == rem_reg[SRV_W:0]) srv_reg <= ptr_reg;
            seen_reg <= seen_reg + 1'b1;
        end

        if (cmd.sum_start) sum_reg <= '0;
        else if (cmd.sum_step) sum_reg <= sum_reg + SUM_W'(cur);

        if (cmd.update) begin
            res_idled <= (op_reg != OP_DISPATCH) && old_c != '0
                         && COUNT_WIDTH'(done_reg) >= old_c;
        end
    end

    assign len_ix = (op_reg == OP_DISPATCH) ? srv_reg : idx_reg;
    assign res_server = len_ix;
    assign res_length = 16'(qlen_reg[len_ix]);
    assign res_total  = (sum_reg > SUM_W'(20'hFFFFF)) ? 20'hFFFFF : TOTAL_W'(sum_reg);
endmodule

// ===== rtl/core/idle_aware_load_dispatcher_top.sv =====
// Top level of the idle-aware load dispatcher.
// Instantiates iald_ctrl and iald_dp; uses iald_pkg.
//
// Input channel s_*: one transfer is either a dispatch (operation 0) that
// sends task_count tasks to a server picked by the configured policy, or a
// completion (operation 1) at server_index. Each transfer yields exactly one
// result transfer on m_*: chosen server, its new count, the idle flag and the
// total count over all servers.
// Config channel cfg_*: index 0 sets the policy, index 1 the history depth.
// Processing runs from the input transfer to m_valid through the scan, the
// serial modulo of the random value, the candidate walk, the update, the
// total sum and the output load; the walk is skipped when the policy picks
// directly.
// One item is in flight at a time; s_ready returns the cycle after the result
// is loaded.
// The result sits in an output register; the next item is taken once it has
// moved there, even if the receiver stalls the previous result. The next
// result then waits until m_ready frees the register.
// Reset clears all counts, the history fill, the last-idle server and the
// registers to policy 0 and depth 1.
module idle_aware_load_dispatcher_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic [7:0]                   s_task_count,
    input  logic [3:0]                   s_server_index,
    input  logic [15:0]                  s_done_count,
    input  logic [15:0]                  s_random_pick,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [3:0]                   m_chosen_server,
    output logic [15:0]                  m_server_length,
    output logic                         m_server_became_idle,
    output logic [19:0]                  m_total_tasks,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [3:0]                   cfg_data
);
    import iald_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic in_ready;
    logic [SRV_W-1:0]   r_srv;
    logic [15:0]        r_len;
    logic               r_idle;
    logic [TOTAL_W-1:0] r_tot;
    logic m_valid_reg;
    logic out_busy;

    assign out_busy  = m_valid_reg && !m_ready;
    assign s_ready   = in_ready;
    assign cfg_ready = 1'b1;

    iald_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(s_valid && in_ready),
        .out_busy(out_busy), .sts(sts), .cmd(cmd), .in_ready(in_ready)
    );

    iald_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_operation(s_operation), .s_task_count(s_task_count),
        .s_server_index(s_server_index), .s_done_count(s_done_count),
        .s_random_pick(s_random_pick),
        .res_server(r_srv), .res_length(r_len), .res_idled(r_idle), .res_total(r_tot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_chosen_server      <= r_srv;
            m_server_length      <= r_len;
            m_server_became_idle <= r_idle;
            m_total_tasks        <= r_tot;
        end
    end

    assign m_valid = m_valid_reg;
endmodule

// ===== rtl/core/iald_checker.sv =====
// Port-level checker for idle_aware_load_dispatcher_top, bound to the top.
// Depends only on the top level's ports.
module iald_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_chosen_server,
    input logic [15:0] m_server_length,
    input logic        m_server_became_idle
);
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chosen_server))
        else $error("result dropped while stalled");
    a_idle_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_server_became_idle |-> m_server_length == 16'd0)
        else $error("idle flag with nonzero length");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken while busy");
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind idle_aware_load_dispatcher_top iald_checker u_iald_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_chosen_server(m_chosen_server),
    .m_server_length(m_server_length), .m_server_became_idle(m_server_became_idle)
);
